[hw/rtl/palindrome_word_filter_assert.svh]
// Assertion helpers shared by the RTL; every use expects clk_i and rst_ni in scope.
`ifndef PALINDROME_WORD_FILTER_ASSERT_SVH
`define PALINDROME_WORD_FILTER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PWF_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define PWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pwf_pkg.sv]
package pwf_pkg;

  // Default and largest word length; word_length is a 6-bit count.
  localparam int unsigned MAX_WORD_DEF = 63;
  localparam int unsigned LEN_W        = 6;

  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;
  localparam logic [7:0] CHAR_HYPHEN  = 8'd45;
  localparam logic [7:0] CHAR_UNDER   = 8'd95;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic             load;     // store a word byte
    logic             rotate;   // rotate both rows down by one cell
    logic [LEN_W-1:0] wr_idx;   // cell that takes the new byte in row A
    logic [LEN_W-1:0] top_idx;  // cell that takes the wrapped byte
  } cell_ctrl_t;

  function automatic logic is_word_byte(input logic [7:0] c);
    return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
           ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
           ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9)) ||
           (c == CHAR_HYPHEN) || (c == CHAR_UNDER);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ? c + CASE_OFFSET : c;
  endfunction

endpackage

[hw/rtl/palindrome_word_filter.sv]
// Palindrome word filter.
// Input stream (s_axis): one text byte per transaction in tdata; tlast marks
// the end of input, which closes the pending word (tdata is then ignored).
// Output stream (m_axis): the bytes of every word that reads the same both
// ways (letters folded to lower case), in original case, with a newline ahead
// of every word but the first one since reset; tlast flags the final byte of
// the run caused by one input transaction. Closes that yield nothing, and
// word bytes, produce no output transaction.
// A closing byte for an n-byte word starts a check pass through the cell
// row up to the first mismatch or the last byte, then an emission pass of n
// bytes (n + 1 with the newline). The row rotates one step per cycle in the
// check pass, and in emission while the output register is free; input is
// taken again after a mismatch or once the last output byte is registered.
// Reset clears the word length, overflow flag and first-word flag; the cells
// hold no reset value. A stalled receiver holds the output register, and the
// emission pass waits on it without losing or repeating a byte.
// Words longer than MAX_WORD bytes are dropped when they close.
module palindrome_word_filter #(
  parameter int unsigned MAX_WORD = pwf_pkg::MAX_WORD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // end_of_input
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // run_last
);

  pwf_pkg::cell_ctrl_t cell_ctrl;
  logic [7:0]          a0, b0;

  // Sequence the fill, check and emission passes.
  pwf_ctrl #(
    .MAX_WORD(MAX_WORD)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .s_tdata_i (s_axis_tdata_i),
    .s_tlast_i (s_axis_tlast_i),
    .s_tready_o(s_axis_tready_o),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tdata_o (m_axis_tdata_o),
    .m_tlast_o (m_axis_tlast_o),
    .m_tready_i(m_axis_tready_i),
    .a0_i      (a0),
    .b0_i      (b0),
    .ctrl_o    (cell_ctrl)
  );

  // Hold the word in forward and reversed order; rotate to compare and emit.
  pwf_chain #(
    .MAX_WORD(MAX_WORD)
  ) u_chain (
    .clk_i    (clk_i),
    .ctrl_i   (cell_ctrl),
    .in_byte_i(s_axis_tdata_i),
    .a0_o     (a0),
    .b0_o     (b0)
  );

endmodule

[hw/rtl/pwf_cell.sv]
// One character cell: row A holds the word in order, row B holds it reversed.
module pwf_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  pwf_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          in_byte_i,
  input  logic [7:0]          a_up_i,
  input  logic [7:0]          b_up_i,
  input  logic [7:0]          b_dn_i,
  input  logic [7:0]          wrap_a_i,
  input  logic [7:0]          wrap_b_i,
  output logic [7:0]          a_o,
  output logic [7:0]          b_o
);

  localparam logic [pwf_pkg::LEN_W-1:0] MyIdx = pwf_pkg::LEN_W'(IDX);

  logic [7:0] a_q, a_d;
  logic [7:0] b_q, b_d;
  logic       is_top;

  assign is_top = (ctrl_i.top_idx == MyIdx);

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    if (ctrl_i.load) begin
      if (ctrl_i.wr_idx == MyIdx) begin
        a_d = in_byte_i;
      end
      b_d = b_dn_i;
    end else if (ctrl_i.rotate) begin
      a_d = is_top ? wrap_a_i : a_up_i;
      b_d = is_top ? wrap_b_i : b_up_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

[hw/rtl/pwf_chain.sv]
// Row of character cells; cell 0 is the read end of both rows.
module pwf_chain #(
  parameter int unsigned MAX_WORD = pwf_pkg::MAX_WORD_DEF
) (
  input  logic                clk_i,
  input  pwf_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          in_byte_i,
  output logic [7:0]          a0_o,
  output logic [7:0]          b0_o
);

  logic [7:0] a_w [MAX_WORD];
  logic [7:0] b_w [MAX_WORD];

  for (genvar k = 0; k < MAX_WORD; k++) begin : g_cell
    logic [7:0] a_up, b_up, b_dn;

    if (k == MAX_WORD - 1) begin : g_top
      assign a_up = '0;
      assign b_up = '0;
    end else begin : g_mid
      assign a_up = a_w[k+1];
      assign b_up = b_w[k+1];
    end

    if (k == 0) begin : g_first
      assign b_dn = in_byte_i;
    end else begin : g_rest
      assign b_dn = b_w[k-1];
    end

    pwf_cell #(
      .IDX(k)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl_i),
      .in_byte_i(in_byte_i),
      .a_up_i   (a_up),
      .b_up_i   (b_up),
      .b_dn_i   (b_dn),
      .wrap_a_i (a_w[0]),
      .wrap_b_i (b_w[0]),
      .a_o      (a_w[k]),
      .b_o      (b_w[k])
    );
  end

  assign a0_o = a_w[0];
  assign b0_o = b_w[0];

endmodule

[hw/rtl/pwf_ctrl.sv]
// Sequencer: word length, palindrome check pass, emission and output register.
`include "palindrome_word_filter_assert.svh"

module pwf_ctrl #(
  parameter int unsigned MAX_WORD = pwf_pkg::MAX_WORD_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic [7:0]          s_tdata_i,
  input  logic                s_tlast_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  output logic [7:0]          m_tdata_o,
  output logic                m_tlast_o,
  input  logic                m_tready_i,
  input  logic [7:0]          a0_i,
  input  logic [7:0]          b0_i,
  output pwf_pkg::cell_ctrl_t ctrl_o
);

  localparam int unsigned LW = pwf_pkg::LEN_W;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_WORD);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_NL    = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic          too_long_q, too_long_d;
  logic          emitted_q, emitted_d;
  logic          m_valid_q, m_valid_d;
  logic [7:0]    m_data_q, m_data_d;
  logic          m_last_q, m_last_d;

  logic          accept, word_in, out_free, at_end;
  logic          load, rotate;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign word_in    = !s_tlast_i && pwf_pkg::is_word_byte(s_tdata_i);
  assign out_free   = !m_valid_q || m_tready_i;
  assign at_end     = (cnt_q == len_q - LW'(1));

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    too_long_d = too_long_q;
    emitted_d  = emitted_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;
    load       = 1'b0;
    rotate     = 1'b0;

    if (m_valid_q && m_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (word_in) begin
            if (len_q < MaxLen) begin
              load  = 1'b1;
              len_d = len_q + LW'(1);
            end else begin
              too_long_d = 1'b1;
            end
          end else if ((len_q != '0) && !too_long_q) begin
            state_d = ST_CHECK;
            cnt_d   = '0;
          end else begin
            len_d      = '0;
            too_long_d = 1'b0;
          end
        end
      end
      ST_CHECK: begin
        rotate = 1'b1;
        if (pwf_pkg::fold_case(a0_i) != pwf_pkg::fold_case(b0_i)) begin
          state_d = ST_IDLE;
          len_d   = '0;
        end else if (at_end) begin
          state_d = emitted_q ? ST_NL : ST_EMIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + LW'(1);
        end
      end
      ST_NL: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = pwf_pkg::CHAR_NEWLINE;
          m_last_d  = 1'b0;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          rotate    = 1'b1;
          m_valid_d = 1'b1;
          m_data_d  = a0_i;
          m_last_d  = at_end;
          if (at_end) begin
            state_d   = ST_IDLE;
            len_d     = '0;
            emitted_d = 1'b1;
          end else begin
            cnt_d = cnt_q + LW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      len_q      <= '0;
      cnt_q      <= '0;
      too_long_q <= 1'b0;
      emitted_q  <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      too_long_q <= too_long_d;
      emitted_q  <= emitted_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;

  assign ctrl_o.load    = load;
  assign ctrl_o.rotate  = rotate;
  assign ctrl_o.wr_idx  = len_q;
  assign ctrl_o.top_idx = len_q - LW'(1);

  `PWF_ASSERT(a_len_bound, len_q <= MaxLen, "word length beyond store depth")
  `PWF_ASSERT(a_overflow_full, !too_long_q || (len_q == MaxLen), "overflow flag with room left")
  `PWF_ASSERT(a_cnt_in_word, !(state_q == ST_CHECK || state_q == ST_EMIT) || (cnt_q < len_q), "pass counter beyond word")
  `PWF_ASSERT_NEXT(a_emit_done, (state_q == ST_EMIT) && out_free && at_end, (state_q == ST_IDLE) && emitted_q && (len_q == '0), "word end did not close the run")

endmodule
